/* rtl/msb_first_bit_buffer_access_top_defines.svh */
`ifndef MSB_FIRST_BIT_BUFFER_ACCESS_TOP_DEFINES_SVH
`define MSB_FIRST_BIT_BUFFER_ACCESS_TOP_DEFINES_SVH

// Check that cond holds in the same cycle whenever trig holds.
`define MFBA_ASSERT_NOW(label, trig, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |-> (cond)) \
    else $error(msg);

// Check that cond holds in the cycle after trig holds.
`define MFBA_ASSERT_NEXT(label, trig, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (cond)) \
    else $error(msg);

`endif

/* rtl/mfba_pkg.sv */
package mfba_pkg;

  // Bit limits per action
  localparam int unsigned READ_MAX_BITS  = 32;
  localparam int unsigned WRITE_MAX_BITS = 64;

  // Action codes
  localparam logic [2:0] ACT_REWIND = 3'd0;
  localparam logic [2:0] ACT_LOAD   = 3'd1;
  localparam logic [2:0] ACT_READ   = 3'd2;
  localparam logic [2:0] ACT_WRITE  = 3'd3;
  localparam logic [2:0] ACT_SKIP   = 3'd4;
  localparam logic [2:0] ACT_DUMP   = 3'd5;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic clear;     // write one zero byte of the clearing pass
    logic latch;     // capture the incoming transaction
    logic exec;      // rewind, load and skip actions, issue first store read
    logic step;      // consume one byte of a read or write
    logic out_load;  // load the result register
  } mfba_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic clear_done;  // last store entry is being cleared
    logic mem_work;    // read or write with bits to move
    logic more;        // another byte follows this step
    logic out_free;    // result register can take a new result
  } mfba_sts_t;

endpackage

/* rtl/mfba_in_if.sv */
interface mfba_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  action;
  logic [15:0] bit_count;
  logic [63:0] data_value;
  logic [11:0] byte_address;
  logic [7:0]  byte_in;

  modport source (
    output valid, action, bit_count, data_value, byte_address, byte_in,
    input  ready
  );
  modport sink (
    input  valid, action, bit_count, data_value, byte_address, byte_in,
    output ready
  );
endinterface

/* rtl/mfba_out_if.sv */
interface mfba_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] result_value;
  logic [7:0]  byte_out;
  logic        count_error;
  logic        at_end;
  logic [12:0] cursor_index;
  logic [3:0]  bits_remaining;

  modport source (
    output valid, result_value, byte_out, count_error, at_end, cursor_index,
           bits_remaining,
    input  ready
  );
  modport sink (
    input  valid, result_value, byte_out, count_error, at_end, cursor_index,
           bits_remaining,
    output ready
  );
endinterface

/* rtl/mfba_cfg_if.sv */
interface mfba_cfg_if;
  logic        valid;
  logic        ready;
  logic [12:0] buffer_length;

  modport source (
    output valid, buffer_length,
    input  ready
  );
  modport sink (
    input  valid, buffer_length,
    output ready
  );
endinterface

/* rtl/mfba_ram.sv */
module mfba_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4096,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

/* rtl/mfba_ctrl.sv */
`include "msb_first_bit_buffer_access_top_defines.svh"

module mfba_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  output mfba_pkg::mfba_cmd_t  cmd_o,
  input  mfba_pkg::mfba_sts_t  sts_i
);
  import mfba_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DECODE,
    S_STEP,
    S_FINISH
  } state_e;

  state_e state_q, state_d;

  // Decode commands and next state
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_CLEAR: begin
        cmd_o.clear = 1'b1;
        if (sts_i.clear_done) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.latch = 1'b1;
          state_d     = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd_o.exec = 1'b1;
        state_d    = sts_i.mem_work ? S_STEP : S_FINISH;
      end
      S_STEP: begin
        cmd_o.step = 1'b1;
        if (!sts_i.more) begin
          state_d = S_FINISH;
        end
      end
      S_FINISH: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Hold state; the clearing pass runs first after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  `MFBA_ASSERT_NEXT(latch_then_exec_a, cmd_o.latch, cmd_o.exec,
                    "captured transaction was not decoded next cycle")
  `MFBA_ASSERT_NOW(load_when_free_a, cmd_o.out_load, sts_i.out_free,
                   "result register overwritten while still held")
  `MFBA_ASSERT_NEXT(step_follow_a, cmd_o.step,
                    (state_q == S_STEP) || (state_q == S_FINISH),
                    "byte step left the transfer unexpectedly")

endmodule

/* rtl/mfba_datapath.sv */
`include "msb_first_bit_buffer_access_top_defines.svh"

module mfba_datapath #(
  parameter int unsigned STORE_BYTES = 4096
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  mfba_pkg::mfba_cmd_t  cmd_i,
  output mfba_pkg::mfba_sts_t  sts_o,
  // configuration
  input  logic                 cfg_valid_i,
  input  logic [12:0]          cfg_length_i,
  // input transaction payload
  input  logic [2:0]           action_i,
  input  logic [15:0]          bit_count_i,
  input  logic [63:0]          data_value_i,
  input  logic [11:0]          byte_address_i,
  input  logic [7:0]           byte_in_i,
  // result channel
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [63:0]          result_value_o,
  output logic [7:0]           byte_out_o,
  output logic                 count_error_o,
  output logic                 at_end_o,
  output logic [12:0]          cursor_index_o,
  output logic [3:0]           bits_remaining_o
);
  import mfba_pkg::*;

  localparam int unsigned AW        = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
  localparam logic [16:0] STORE_LIM = 17'(STORE_BYTES);
  localparam logic [AW-1:0] LAST_ENTRY = AW'(STORE_BYTES - 1);

  // Registers
  logic [12:0]   len_q;
  logic [2:0]    act_q;
  logic [15:0]   cnt_q;
  logic [63:0]   data_q;
  logic [11:0]   baddr_q;
  logic [7:0]    bin_q;
  logic [12:0]   cursor_q, cursor_d;
  logic [3:0]    bits_q, bits_d;
  logic [6:0]    n_q, n_d;
  logic [31:0]   acc_q, acc_d;
  logic [AW-1:0] clr_q;
  logic          out_valid_q;

  // Store port signals
  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [7:0]    ram_wdata, ram_rdata;

  // Decode of the held transaction
  logic [16:0] end_wide;
  logic [12:0] end_idx;
  logic        cur_in_buf, is_rd, is_wr, cnt_err, baddr_ok;

  assign end_wide   = (17'(len_q) > STORE_LIM) ? STORE_LIM : 17'(len_q);
  assign end_idx    = end_wide[12:0];
  assign cur_in_buf = cursor_q < end_idx;
  assign is_rd      = act_q == ACT_READ;
  assign is_wr      = act_q == ACT_WRITE;
  assign cnt_err    = (is_rd && (cnt_q > 16'(READ_MAX_BITS)))
                   || (is_wr && (cnt_q > 16'(WRITE_MAX_BITS)));
  assign baddr_ok   = 17'(baddr_q) < STORE_LIM;

  // One byte step of a read or write
  logic [3:0]  take, bits_step;
  logic [2:0]  sh;
  logic [7:0]  mask8, chunk, wbits, new_byte;
  logic [5:0]  lo_sh;
  logic [6:0]  n_step;
  logic [31:0] acc_step;
  logic [12:0] cursor_step;
  logic [3:0]  bits_next;

  always_comb begin
    take      = ({3'b000, bits_q} < n_q) ? bits_q : n_q[3:0];
    sh        = 3'(bits_q - take);
    mask8     = 8'((9'd1 << take) - 9'd1);
    lo_sh     = 6'(n_q - 7'(take));
    chunk     = (ram_rdata >> sh) & mask8;
    acc_step  = acc_q | (32'(chunk) << lo_sh[4:0]);
    wbits     = 8'(data_q >> lo_sh) & mask8;
    new_byte  = (ram_rdata & ~(mask8 << sh)) | (wbits << sh);
    n_step    = n_q - 7'(take);
    bits_step = bits_q - take;
    if (bits_step == 4'd0) begin
      cursor_step = cursor_q + 13'd1;
      bits_next   = 4'd8;
    end else begin
      cursor_step = cursor_q;
      bits_next   = bits_step;
    end
  end

  // Skip target position in bits
  logic [16:0] pos;
  logic        skip_sat;

  assign pos      = {1'b0, cursor_q, 3'b000} + 17'(4'd8 - bits_q) + 17'(cnt_q);
  assign skip_sat = pos[16:3] >= 14'(end_idx);

  // Next cursor, remaining count and accumulator
  always_comb begin
    cursor_d = cursor_q;
    bits_d   = bits_q;
    n_d      = n_q;
    acc_d    = acc_q;
    if (cmd_i.latch) begin
      n_d   = bit_count_i[6:0];
      acc_d = '0;
    end
    if (cmd_i.exec) begin
      case (act_q)
        ACT_REWIND: begin
          cursor_d = '0;
          bits_d   = 4'd8;
        end
        ACT_SKIP: begin
          if (cur_in_buf) begin
            if (skip_sat) begin
              cursor_d = end_idx;
              bits_d   = 4'd8;
            end else begin
              cursor_d = pos[15:3];
              bits_d   = 4'd8 - {1'b0, pos[2:0]};
            end
          end
        end
        default: begin
        end
      endcase
    end
    if (cmd_i.step) begin
      n_d      = n_step;
      acc_d    = is_rd ? acc_step : acc_q;
      cursor_d = cursor_step;
      bits_d   = bits_next;
    end
  end

  // Store addressing: next byte during a transfer, else cursor or byte address
  logic [31:0] raddr_wide, cur_wide, baddr_wide, clr_wide;

  always_comb begin
    cur_wide   = 32'(cursor_q);
    baddr_wide = 32'(baddr_q);
    clr_wide   = 32'(clr_q);
    if (cmd_i.step) begin
      raddr_wide = 32'(cursor_d);
    end else if (is_rd || is_wr) begin
      raddr_wide = cur_wide;
    end else begin
      raddr_wide = baddr_wide;
    end
    ram_raddr = raddr_wide[AW-1:0];

    ram_we    = 1'b0;
    ram_waddr = clr_wide[AW-1:0];
    ram_wdata = '0;
    if (cmd_i.clear) begin
      ram_we = 1'b1;
    end else if (cmd_i.step && is_wr) begin
      ram_we    = 1'b1;
      ram_waddr = cur_wide[AW-1:0];
      ram_wdata = new_byte;
    end else if (cmd_i.exec && (act_q == ACT_LOAD) && baddr_ok) begin
      ram_we    = 1'b1;
      ram_waddr = baddr_wide[AW-1:0];
      ram_wdata = bin_q;
    end
  end

  mfba_ram #(
    .WIDTH (8),
    .DEPTH (STORE_BYTES)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Status to the controller
  assign sts_o.clear_done = clr_q == LAST_ENTRY;
  assign sts_o.mem_work   = (is_rd || is_wr) && !cnt_err && (cnt_q != 16'd0) && cur_in_buf;
  assign sts_o.more       = (n_step != 7'd0) && (cursor_step < end_idx);
  assign sts_o.out_free   = !out_valid_q || out_ready_i;

  // Capture the transaction payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      act_q   <= action_i;
      cnt_q   <= bit_count_i;
      data_q  <= data_value_i;
      baddr_q <= byte_address_i;
      bin_q   <= byte_in_i;
    end
  end

  // Control state: length, cursor, counters, result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q       <= '0;
      cursor_q    <= '0;
      bits_q      <= 4'd8;
      n_q         <= '0;
      acc_q       <= '0;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        len_q <= cfg_length_i;
      end
      cursor_q <= cursor_d;
      bits_q   <= bits_d;
      n_q      <= n_d;
      acc_q    <= acc_d;
      if (cmd_i.clear) begin
        clr_q <= clr_q + AW'(1);
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      if (cnt_err) begin
        result_value_o <= '0;
      end else if (is_rd) begin
        result_value_o <= 64'(acc_q);
      end else if (is_wr) begin
        result_value_o <= data_q;
      end else begin
        result_value_o <= '0;
      end
      byte_out_o       <= ((act_q == ACT_DUMP) && baddr_ok) ? ram_rdata : 8'd0;
      count_error_o    <= cnt_err;
      at_end_o         <= !cur_in_buf;
      cursor_index_o   <= cursor_q;
      bits_remaining_o <= bits_q;
    end
  end

  assign out_valid_o = out_valid_q;

  `MFBA_ASSERT_NOW(bits_range_a, 1'b1, (bits_q != 4'd0) && (bits_q <= 4'd8),
                   "bits left in current byte out of range")
  `MFBA_ASSERT_NOW(step_has_bits_a, cmd_i.step, n_q != 7'd0,
                   "byte step with no bits left to move")
  `MFBA_ASSERT_NOW(valid_from_load_a, $rose(out_valid_q), $past(cmd_i.out_load),
                   "result valid rose without a result load")

endmodule

/* rtl/msb_first_bit_buffer_access_top.sv */
// Flow: an input transaction is captured and decoded; a read or write with bits to move
// then steps through the store byte by byte (a read touches at most 5 bytes, a write
// at most 9); the result is loaded once the result register is free. No new transaction
// is taken until then. The single byte-wide store port does a read-modify-write per byte.
// Reset: asynchronous, active low; cursor 0, 8 bits left, length 0, then a clearing
// pass zeroes every store entry while no input transaction is taken.
module msb_first_bit_buffer_access_top #(
  parameter int unsigned STORE_BYTES = 4096
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  mfba_in_if.sink           in_i,
  mfba_out_if.source        out_o,
  mfba_cfg_if.sink          cfg_i
);
  import mfba_pkg::*;

  mfba_cmd_t cmd;
  mfba_sts_t sts;
  logic      in_ready;

  // Configuration writes are always taken
  assign cfg_i.ready = 1'b1;
  assign in_i.ready  = in_ready;

  mfba_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  mfba_datapath #(
    .STORE_BYTES (STORE_BYTES)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .cfg_valid_i      (cfg_i.valid),
    .cfg_length_i     (cfg_i.buffer_length),
    .action_i         (in_i.action),
    .bit_count_i      (in_i.bit_count),
    .data_value_i     (in_i.data_value),
    .byte_address_i   (in_i.byte_address),
    .byte_in_i        (in_i.byte_in),
    .out_valid_o      (out_o.valid),
    .out_ready_i      (out_o.ready),
    .result_value_o   (out_o.result_value),
    .byte_out_o       (out_o.byte_out),
    .count_error_o    (out_o.count_error),
    .at_end_o         (out_o.at_end),
    .cursor_index_o   (out_o.cursor_index),
    .bits_remaining_o (out_o.bits_remaining)
  );

endmodule
